// ----- design/trial_division_prime_generator_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the trial division prime generator
// Shared property forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef TRIAL_DIVISION_PRIME_GENERATOR_DEFINES_SVH
`define TRIAL_DIVISION_PRIME_GENERATOR_DEFINES_SVH

// same-cycle implication, checked outside reset
`define TDPG_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("tdpg check failed");

// next-cycle implication, checked outside reset
`define TDPG_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("tdpg check failed");

`endif

// ----- design/tdpg_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdpg_pkg
// Types and constants shared by the prime generator modules.
// ----------------------------------------------------------------------------
package tdpg_pkg;

    localparam int CAND_W          = 32;
    localparam int ROOT_W          = CAND_W / 2;
    localparam int COUNT_W         = 28;
    localparam int TABLE_DEPTH_DEF = 8192;
    localparam int VALUE_WIDTH_DEF = 32;

    localparam logic [COUNT_W-1:0] COUNT_MAX    = {COUNT_W{1'b1}};
    localparam logic [2:0]         WHEEL_TOGGLE = 3'd6;
    localparam logic [2:0]         WHEEL_INIT   = 3'd4;
    localparam logic [CAND_W:0]    FIRST_CAND   = 33'd2;
    localparam logic [CAND_W-1:0]  LIMIT_RESET  = 32'd1000;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQRT,
        ST_READ,
        ST_LOAD,
        ST_DIV,
        ST_UPD,
        ST_OUT
    } tdpg_state_t;

endpackage

// ----- design/tdpg_sqrt.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdpg_sqrt
// Digit-by-digit integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module tdpg_sqrt
    import tdpg_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [CAND_W-1:0] x,
    output logic              done,
    output logic [ROOT_W-1:0] root
);

    localparam logic [CAND_W-1:0] ONE_INIT = {2'b01, {(CAND_W-2){1'b0}}};

    logic              busy_reg;
    logic [CAND_W-1:0] op_reg;
    logic [CAND_W-1:0] res_reg;
    logic [CAND_W-1:0] one_reg;
    logic [CAND_W-1:0] trial;

    assign trial = res_reg + one_reg;
    assign done  = busy_reg && (one_reg == '0);
    assign root  = res_reg[ROOT_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else if (start) begin
            busy_reg <= 1'b1;
        end else if (done) begin
            busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            op_reg  <= x;
            res_reg <= '0;
            one_reg <= ONE_INIT;
        end else if (busy_reg && one_reg != '0) begin
            if (op_reg >= trial) begin
                op_reg  <= op_reg - trial;
                res_reg <= (res_reg >> 1) + one_reg;
            end else begin
                res_reg <= res_reg >> 1;
            end
            one_reg <= one_reg >> 2;
        end
    end

endmodule

// ----- design/tdpg_rem.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdpg_rem
// Restoring radix-2 divider that keeps only the remainder.
// ----------------------------------------------------------------------------
module tdpg_rem
    import tdpg_pkg::*;
#(
    parameter int WIDTH = CAND_W
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [WIDTH-1:0] dividend,
    input  logic [WIDTH-1:0] divisor,
    output logic             done,
    output logic [WIDTH-1:0] remainder
);

    localparam int CW = $clog2(WIDTH + 1);

    logic             busy_reg;
    logic [CW-1:0]    cnt_reg;
    logic [WIDTH-1:0] rem_reg;
    logic [WIDTH-1:0] quo_reg;
    logic [WIDTH-1:0] div_reg;
    logic [WIDTH:0]   shifted;

    assign shifted   = {rem_reg, quo_reg[WIDTH-1]};
    assign done      = busy_reg && (cnt_reg == '0);
    assign remainder = rem_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else if (start) begin
            busy_reg <= 1'b1;
        end else if (done) begin
            busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            quo_reg <= dividend;
            div_reg <= divisor;
            cnt_reg <= CW'(WIDTH);
        end else if (busy_reg && cnt_reg != '0) begin
            if (shifted >= {1'b0, div_reg}) begin
                rem_reg <= WIDTH'(shifted - {1'b0, div_reg});
            end else begin
                rem_reg <= shifted[WIDTH-1:0];
            end
            quo_reg <= quo_reg << 1;
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

endmodule

// ----- design/tdpg_table.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdpg_table
// Prime table: one write port, one registered read port.
// ----------------------------------------------------------------------------
module tdpg_table
    import tdpg_pkg::*;
#(
    parameter int DEPTH = TABLE_DEPTH_DEF,
    parameter int WIDTH = VALUE_WIDTH_DEF
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- design/trial_division_prime_generator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trial_division_prime_generator
// Trial division prime generator with twin and triplet counters.
// ----------------------------------------------------------------------------
// Each request tests one candidate (2, 3, 5, 7, 11, ... on a 2/4 wheel) and
// returns one result. An item first takes the square root bound, one root
// bit per cycle, then for each stored prime tried a table read, an operand
// load and a bit-serial remainder over max(VALUE_WIDTH, 32) bits, one bit per
// cycle, then a count update and a result register stage. A composite stops
// at its first divisor. A request past upper_limit skips the bound and the
// trials and goes straight to the output state, which registers a done result
// once the result register is free and returns to idle, where the next request
// can be taken. The next request is taken while the previous result still
// waits on the result channel; its own result holds until that one drains.
// There is no clearing pass: only table entries already written are ever read.
module trial_division_prime_generator
    import tdpg_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    // configuration write channel: upper_limit
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [CAND_W-1:0]  cfg_data,
    // request channel
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_restart,
    // result channel
    output logic               m_valid,
    input  logic               m_ready,
    output logic [CAND_W-1:0]  m_candidate,
    output logic               m_is_prime,
    output logic               m_done_res,
    output logic [COUNT_W-1:0] m_prime_count,
    output logic [COUNT_W-1:0] m_twin_count,
    output logic [COUNT_W-1:0] m_triplet_count,
    output logic               m_table_full
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int DW    = (VALUE_WIDTH > CAND_W) ? VALUE_WIDTH : CAND_W;
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);

    tdpg_state_t state_reg, state_next;

    logic [CAND_W-1:0]  limit_reg;
    logic [CAND_W:0]    next_cand_reg;
    logic [2:0]         wheel_reg;
    logic [CNT_W-1:0]   stored_reg;
    logic [CAND_W-1:0]  last_reg;
    logic [CAND_W-1:0]  prior_reg;
    logic [COUNT_W-1:0] primes_reg;
    logic [COUNT_W-1:0] twins_reg;
    logic [COUNT_W-1:0] trips_reg;

    logic [CAND_W-1:0]  cand_reg;
    logic [ROOT_W:0]    bound_reg;
    logic [CNT_W-1:0]   k_reg;
    logic [DW-1:0]      d_reg;
    logic               prime_reg;
    logic               done_reg;
    logic               m_valid_reg;

    logic               acc;
    logic [CAND_W:0]    cand_in;
    logic               over_limit;
    logic               out_free;
    logic               sq_start, sq_done;
    logic [ROOT_W-1:0]  sq_root;
    logic               dv_start, dv_done;
    logic [DW-1:0]      dv_rem;
    logic               hit;
    logic               past_bound;
    logic               last_k;
    logic               rd_en, wr_en;
    logic [VALUE_WIDTH-1:0] rd_data;
    logic [2:0]         wheel_flip;
    logic [CAND_W-1:0]  gap;

    // ---- request side --------------------------------------------------------
    assign acc        = s_valid && s_ready;
    assign cand_in    = s_restart ? FIRST_CAND : next_cand_reg;
    assign over_limit = cand_in > {1'b0, limit_reg};
    assign out_free   = !m_valid_reg || m_ready;
    assign cfg_ready  = 1'b1;

    // ---- trial loop decisions -----------------------------------------------
    assign hit        = dv_done && (d_reg != '0) && (dv_rem == '0);
    assign past_bound = d_reg >= DW'(bound_reg);
    assign last_k     = (k_reg + 1'b1) >= stored_reg;
    assign wheel_flip = wheel_reg ^ WHEEL_TOGGLE;
    assign gap        = last_reg - prior_reg;

    // ---- next state -------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (acc) begin
                    state_next = over_limit ? ST_OUT : ST_SQRT;
                end
            end
            ST_SQRT: begin
                if (sq_done) begin
                    state_next = (stored_reg > CNT_W'(1)) ? ST_READ : ST_UPD;
                end
            end
            ST_READ: state_next = ST_LOAD;
            ST_LOAD: state_next = ST_DIV;
            ST_DIV: begin
                if (dv_done) begin
                    state_next = (hit || past_bound || last_k) ? ST_UPD : ST_READ;
                end
            end
            ST_UPD: state_next = ST_OUT;
            ST_OUT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // ---- control outputs ------------------------------------------------------
    always_comb begin
        s_ready  = (state_reg == ST_IDLE);
        sq_start = (state_reg == ST_IDLE) && acc && !over_limit;
        rd_en    = (state_reg == ST_READ);
        dv_start = (state_reg == ST_LOAD);
        wr_en    = (state_reg == ST_UPD) && prime_reg && (stored_reg < DEPTH_C);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // ---- configuration register ----------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= LIMIT_RESET;
        end else if (cfg_valid && cfg_ready) begin
            limit_reg <= cfg_data;
        end
    end

    // ---- generator state: restart, advance, count ---------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn || (acc && s_restart)) begin
            next_cand_reg <= FIRST_CAND;
            wheel_reg     <= WHEEL_INIT;
            stored_reg    <= '0;
            last_reg      <= '0;
            prior_reg     <= '0;
            primes_reg    <= '0;
            twins_reg     <= '0;
            trips_reg     <= '0;
        end else if (state_reg == ST_UPD) begin
            if (prime_reg) begin
                if (last_reg != '0 && (cand_reg - last_reg) == CAND_W'(2)
                        && twins_reg != COUNT_MAX) begin
                    twins_reg <= twins_reg + 1'b1;
                end
                if ((gap == CAND_W'(2) || gap == CAND_W'(4))
                        && (cand_reg - prior_reg) == CAND_W'(6)
                        && trips_reg != COUNT_MAX) begin
                    trips_reg <= trips_reg + 1'b1;
                end
                if (primes_reg != COUNT_MAX) begin
                    primes_reg <= primes_reg + 1'b1;
                end
                if (stored_reg < DEPTH_C) begin
                    stored_reg <= stored_reg + 1'b1;
                end
                prior_reg <= last_reg;
                last_reg  <= cand_reg;
            end
            // advance: 2 -> 3 -> 5, then alternate steps of 2 and 4
            if (cand_reg < CAND_W'(5)) begin
                next_cand_reg <= (cand_reg == CAND_W'(2)) ? (CAND_W+1)'(3) : (CAND_W+1)'(5);
            end else begin
                wheel_reg     <= wheel_flip;
                next_cand_reg <= {1'b0, cand_reg} + (CAND_W+1)'(wheel_flip);
            end
        end
    end

    // ---- per-item working registers ------------------------------------------
    always_ff @(posedge aclk) begin
        if (acc) begin
            cand_reg  <= cand_in[CAND_W-1:0];
            done_reg  <= over_limit;
            prime_reg <= 1'b1;
            k_reg     <= CNT_W'(1);
        end
        if (sq_done) begin
            bound_reg <= {1'b0, sq_root} + 1'b1;
        end
        if (state_reg == ST_LOAD) begin
            d_reg <= DW'(rd_data);
        end
        if (state_reg == ST_DIV && dv_done) begin
            if (hit) begin
                prime_reg <= 1'b0;
            end
            k_reg <= k_reg + 1'b1;
        end
    end

    // ---- result register ------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (state_reg == ST_OUT && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_OUT && out_free) begin
            m_candidate     <= done_reg ? '0 : cand_reg;
            m_is_prime      <= !done_reg && prime_reg;
            m_done_res      <= done_reg;
            m_prime_count   <= primes_reg;
            m_twin_count    <= twins_reg;
            m_triplet_count <= trips_reg;
            m_table_full    <= (stored_reg >= DEPTH_C);
        end
    end

    assign m_valid = m_valid_reg;

    // ---- units ------------------------------------------------------------------
    tdpg_sqrt u_sqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (sq_start),
        .x       (cand_in[CAND_W-1:0]),
        .done    (sq_done),
        .root    (sq_root)
    );

    tdpg_rem #(
        .WIDTH (DW)
    ) u_rem (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (dv_start),
        .dividend  (DW'(cand_reg)),
        .divisor   (DW'(rd_data)),
        .done      (dv_done),
        .remainder (dv_rem)
    );

    tdpg_table #(
        .DEPTH (TABLE_DEPTH),
        .WIDTH (VALUE_WIDTH)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (stored_reg[IDX_W-1:0]),
        .wr_data (VALUE_WIDTH'(cand_reg)),
        .rd_en   (rd_en),
        .rd_addr (k_reg[IDX_W-1:0]),
        .rd_data (rd_data)
    );

endmodule

// ----- design/tdpg_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdpg_checker
// Port-level checks on the prime generator result channel.
// ----------------------------------------------------------------------------
`include "trial_division_prime_generator_defines.svh"

module tdpg_checker
    import tdpg_pkg::*;
(
    input logic              aclk,
    input logic              aresetn,
    input logic              m_valid,
    input logic              m_ready,
    input logic [CAND_W-1:0] m_candidate,
    input logic              m_is_prime,
    input logic              m_done_res
);

    `TDPG_ASSERT_NEXT(a_hold, m_valid && !m_ready, m_valid && $stable(m_candidate))
    `TDPG_ASSERT_NOW(a_done_blank, m_valid && m_done_res, m_candidate == '0 && !m_is_prime)
    `TDPG_ASSERT_NOW(a_tested_min, m_valid && !m_done_res, m_candidate >= CAND_W'(2))

endmodule

bind trial_division_prime_generator tdpg_checker u_tdpg_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_candidate (m_candidate),
    .m_is_prime  (m_is_prime),
    .m_done_res  (m_done_res)
);

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the trial division prime generator. A short table of
// directed requests covers startup, the limit extremes and restarts, then
// random requests run under several limits. Every result is checked against
// a behavioral prime sieve kept alongside the block.
// ----------------------------------------------------------------------------
module tb_top;
    import tdpg_pkg::*;

    localparam int TDEPTH      = TABLE_DEPTH_DEF;
    localparam int RAND_ITEMS  = 41;
    localparam int LONG_HOLD   = 3000;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int DIR_ROWS    = 16;

    typedef struct packed {
        logic [CAND_W-1:0]  cand;
        logic               prime;
        logic               done;
        logic [COUNT_W-1:0] primes;
        logic [COUNT_W-1:0] twins;
        logic [COUNT_W-1:0] triplets;
        logic               full;
    } prime_res_t;

    // One directed request: optional limit write before it, and a typed
    // candidate / primality / done check where the answer is obvious.
    typedef struct {
        bit                cfg_wr;
        logic [CAND_W-1:0] cfg_val;
        bit                restart;
        bit                typed;
        logic [CAND_W-1:0] cand;
        bit                prime;
        bit                done;
    } dir_row_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [CAND_W-1:0]  cfg_data = '0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic               s_restart = 1'b0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [CAND_W-1:0]  m_candidate;
    logic               m_is_prime;
    logic               m_done_res;
    logic [COUNT_W-1:0] m_prime_count;
    logic [COUNT_W-1:0] m_twin_count;
    logic [COUNT_W-1:0] m_triplet_count;
    logic               m_table_full;

    trial_division_prime_generator uut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_restart(s_restart),
        .m_valid(m_valid), .m_ready(m_ready), .m_candidate(m_candidate),
        .m_is_prime(m_is_prime), .m_done_res(m_done_res),
        .m_prime_count(m_prime_count), .m_twin_count(m_twin_count),
        .m_triplet_count(m_triplet_count), .m_table_full(m_table_full)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Sieve state mirrored from the block
    // ------------------------------------------------------------------
    logic [CAND_W-1:0]  sieve_table [TDEPTH];
    int                 sieve_stored;
    logic [CAND_W:0]    sieve_next;
    logic [2:0]         sieve_step;
    logic [CAND_W-1:0]  sieve_last;
    logic [CAND_W-1:0]  sieve_prior;
    logic [COUNT_W-1:0] sieve_primes;
    logic [COUNT_W-1:0] sieve_twins;
    logic [COUNT_W-1:0] sieve_triplets;
    logic [CAND_W-1:0]  sieve_limit;

    prime_res_t pending_results[$];
    int         mismatches = 0;
    int         cycles = 0;
    bit         hold_pending = 1'b0;

    function automatic void sieve_clear();
        sieve_stored   = 0;
        sieve_next     = FIRST_CAND;
        sieve_step     = WHEEL_INIT;
        sieve_last     = '0;
        sieve_prior    = '0;
        sieve_primes   = '0;
        sieve_twins    = '0;
        sieve_triplets = '0;
    endfunction

    function automatic logic [COUNT_W-1:0] bump(input logic [COUNT_W-1:0] v);
        return (v == COUNT_MAX) ? v : v + 1'b1;
    endfunction

    // floor of the square root; candidates here stay small
    function automatic logic [CAND_W:0] floor_root(input logic [CAND_W:0] x);
        longint unsigned r;
        r = 0;
        while ((r + 1) * (r + 1) <= x) r++;
        return r[CAND_W:0];
    endfunction

    // Test the next candidate and, unless it is past the limit, advance the sieve.
    function automatic prime_res_t sieve_advance(input bit restart);
        prime_res_t      r;
        logic [CAND_W:0] c;
        logic [CAND_W:0] bound;
        logic [CAND_W-1:0] gap;
        bit              prime;
        r = '0;
        if (restart) sieve_clear();
        c = sieve_next;
        if (c > {1'b0, sieve_limit}) begin
            r.done = 1'b1;
        end else begin
            bound = 1 + floor_root(c);
            prime = 1'b1;
            for (int k = 1; k < sieve_stored && k < TDEPTH; k++) begin
                if (sieve_table[k] != 0 && c % sieve_table[k] == 0) begin
                    prime = 1'b0;
                    break;
                end
                if (sieve_table[k] >= bound) break;
            end
            if (prime) begin
                // twin needs a previous prime; (3,5) counts
                if (sieve_last != 0 && c - sieve_last == 2)
                    sieve_twins = bump(sieve_twins);
                gap = sieve_last - sieve_prior;
                if ((gap == 2 || gap == 4) && c - sieve_prior == 6)
                    sieve_triplets = bump(sieve_triplets);
                sieve_prior = sieve_last;
                sieve_last  = c[CAND_W-1:0];
                if (sieve_stored < TDEPTH) begin
                    sieve_table[sieve_stored] = c[CAND_W-1:0];
                    sieve_stored++;
                end
                sieve_primes = bump(sieve_primes);
            end
            if (c < 5) begin
                sieve_next = (c == 2) ? 33'd3 : 33'd5;
            end else begin
                sieve_step = sieve_step ^ WHEEL_TOGGLE;
                sieve_next = c + sieve_step;
            end
            r.cand  = c[CAND_W-1:0];
            r.prime = prime;
        end
        r.primes   = sieve_primes;
        r.twins    = sieve_twins;
        r.triplets = sieve_triplets;
        r.full     = (sieve_stored >= TDEPTH);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Request side: bursts of random length with random gaps
    // ------------------------------------------------------------------
    int burst_left = 0;

    // Valid stays up after an accept when the burst goes on; drop it only
    // for a gap, a limit write or the end of the run.
    task automatic send_request(input bit restart, output prime_res_t r);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
            if (gap != 0) begin
                s_valid   <= 1'b0;
                s_restart <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 8);
        end
        burst_left--;
        s_valid   <= 1'b1;
        s_restart <= restart;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        // accepted at this edge: predict now
        r = sieve_advance(restart);
        pending_results.insert(pending_results.size(), r);
    endtask

    // Write the limit only once all results are back and the block rests.
    task automatic write_limit(input logic [CAND_W-1:0] v);
        s_valid   <= 1'b0;
        s_restart <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (5) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        sieve_limit = v;
        cfg_valid <= 1'b0;
    endtask

    dir_row_t dir_rows [DIR_ROWS] = '{
        // after reset: 2, 3, 5 under the default limit
        '{0, 0,             0, 1, 2,  1, 0},
        '{0, 0,             0, 1, 3,  1, 0},
        '{0, 0,             0, 1, 5,  1, 0},
        // limit 2: restart tests only 2, then done
        '{1, 2,             1, 1, 2,  1, 0},
        '{0, 0,             0, 1, 0,  0, 1},
        '{0, 0,             0, 1, 0,  0, 1},
        // limit 5 resumes with 3 and 5, then done
        '{1, 5,             0, 1, 3,  1, 0},
        '{0, 0,             0, 1, 5,  1, 0},
        '{0, 0,             0, 1, 0,  0, 1},
        // full-range limit resumes the wheel
        '{1, 32'hFFFF_FFFF, 0, 1, 7,  1, 0},
        '{0, 0,             0, 1, 11, 1, 0},
        '{0, 0,             0, 0, 0,  0, 0},
        '{0, 0,             0, 0, 0,  0, 0},
        '{0, 0,             0, 0, 0,  0, 0},
        '{0, 0,             0, 1, 23, 1, 0},
        '{0, 0,             1, 1, 2,  1, 0}
    };

    initial begin
        prime_res_t r;
        logic [CAND_W-1:0] limits [3];
        sieve_clear();
        sieve_limit = LIMIT_RESET;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_rows[i]) begin
            if (dir_rows[i].cfg_wr) write_limit(dir_rows[i].cfg_val);
            send_request(dir_rows[i].restart, r);
            if (dir_rows[i].typed && (r.cand !== dir_rows[i].cand ||
                r.prime !== dir_rows[i].prime || r.done !== dir_rows[i].done)) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("directed row %0d: sieve gives cand %0d prime %0b done %0b",
                             i, r.cand, r.prime, r.done);
            end
        end

        limits[0] = 32'hFFFF_FFFF;
        limits[1] = $urandom_range(5, 200);
        limits[2] = $urandom_range(200, 1200);
        foreach (limits[p]) begin
            write_limit(limits[p]);
            for (int n = 0; n < RAND_ITEMS; n++) begin
                // one long receiver hold-off so the block backs up
                if (p == 0 && n == 10) hold_pending = 1'b1;
                send_request($urandom_range(0, 24) == 0, r);
            end
        end

        s_valid   <= 1'b0;
        s_restart <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
        if (mismatches == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

    // ------------------------------------------------------------------
    // Result side: stall pattern plus one long hold
    // ------------------------------------------------------------------
    initial begin
        int mode;
        int run;
        mode = 0;
        run  = 0;
        forever begin
            @(posedge aclk);
            if (hold_pending) begin
                hold_pending = 1'b0;
                m_ready <= 1'b0;
                repeat (LONG_HOLD - 1) @(posedge aclk);
            end else begin
                if (run == 0) begin
                    mode = $urandom_range(0, 2);
                    run  = $urandom_range(5, 60);
                end
                run--;
                case (mode)
                    0: m_ready <= 1'b1;                          // no stalls
                    1: m_ready <= ($urandom_range(0, 3) != 0);  // light stalls
                    default: m_ready <= ($urandom_range(0, 1) == 0);
                endcase
            end
        end
    end

    // Check each result against the oldest expectation, field by field.
    always @(posedge aclk) begin
        prime_res_t e;
        prime_res_t got;
        if (aresetn && m_valid && m_ready) begin
            got = '{m_candidate, m_is_prime, m_done_res, m_prime_count,
                    m_twin_count, m_triplet_count, m_table_full};
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: cand %0d", m_candidate);
            end else begin
                e = pending_results.pop_front();
                if (got.cand !== e.cand || got.prime !== e.prime ||
                    got.done !== e.done || got.primes !== e.primes ||
                    got.twins !== e.twins || got.triplets !== e.triplets ||
                    got.full !== e.full) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch exp c=%0d p=%0b d=%0b n=%0d t=%0d r=%0d f=%0b",
                                  " got c=%0d p=%0b d=%0b n=%0d t=%0d r=%0d f=%0b"},
                                 e.cand, e.prime, e.done, e.primes, e.twins,
                                 e.triplets, e.full, got.cand, got.prime,
                                 got.done, got.primes, got.twins,
                                 got.triplets, got.full);
                end
            end
        end
    end

    // Drop the run if it hangs.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

endmodule
